// ----- sv/shl_pkg.sv -----
package shl_pkg;

    // payload widths fixed by the item format
    localparam int unsigned CH_W     = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned REASON_W = 3;

    // characters of interest
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;

    // parser phase
    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_GOT0       = 3'd1,
        PH_FIRSTDIG   = 3'd2,
        PH_DIGITS     = 3'd3,
        PH_TRAIL      = 3'd4,
        PH_AFTERCOMMA = 3'd5,
        PH_REJECTED   = 3'd6
    } t_phase;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_MORE   = 2'd0,
        KIND_LAST   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // reject reasons
    typedef enum logic [REASON_W-1:0] {
        RSN_NONE      = 3'd0,
        RSN_PREFIX    = 3'd1,
        RSN_NO_DIGITS = 3'd2,
        RSN_OVERFLOW  = 3'd3,
        RSN_ZERO      = 3'd4,
        RSN_JUNK      = 3'd5,
        RSN_COMMA     = 3'd6
    } t_reason;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] d;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CH_W-1:0] c);
        t_hex h;
        h.ok = 1'b0;
        h.d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok = 1'b1;
            h.d  = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok = 1'b1;
            h.d  = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok = 1'b1;
            h.d  = 4'(c - 8'h37);
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

// ----- sv/shl_if.sv -----
// character channel
interface shl_ch_if;
    logic                           valid;
    logic                           ready;
    logic [shl_pkg::CH_W-1:0]       ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// result channel
interface shl_res_if;
    logic                           valid;
    logic                           ready;
    logic [shl_pkg::KIND_W-1:0]     kind;
    logic [shl_pkg::VALUE_W-1:0]    value;
    logic [shl_pkg::REASON_W-1:0]   reject_reason;

    modport source (output valid, output kind, output value, output reject_reason,
                    input ready);
    modport sink   (input valid, input kind, input value, input reject_reason,
                    output ready);
endinterface

// ----- sv/strict_hex_list_parser_core.sv -----
// channel   dir  payload                          handshake
// i_in      in   ch[7:0]                          valid/ready
// o_out     out  kind[1:0] value[63:0]            valid/ready
//                reject_reason[2:0]
//
// one character per cycle while the input is not stalled; a result shows in the cycle after its character
// the phase and accumulator update in the cycle the character is taken
// a single output register holds a result; input stalls only while it is
// full and not being taken
// synchronous active-low reset returns to token start with a zero value

module strict_hex_list_parser_core #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    shl_ch_if.sink          i_in,
    shl_res_if.source       o_out
);

    shl_pkg::t_phase              r_phase, n_phase;
    logic [VALUE_BITS-1:0]        r_acc, n_acc;

    logic                         r_out_valid;
    shl_pkg::t_kind               r_kind, n_kind;
    logic [shl_pkg::VALUE_W-1:0]  r_value, n_value;
    shl_pkg::t_reason             r_reason, n_reason;
    logic                         n_emit;

    logic                         accept;
    logic [shl_pkg::CH_W-1:0]     c;
    shl_pkg::t_hex                hx;
    logic                         blank;
    logic                         top_busy;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // character decode
    assign c        = i_in.ch;
    assign hx       = shl_pkg::hex_decode(c);
    assign blank    = shl_pkg::is_blank(c);
    assign top_busy = (r_acc[VALUE_BITS-1 -: 4] != 4'd0);

    // next phase and accumulator
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        unique case (r_phase) inside
            shl_pkg::PH_START, shl_pkg::PH_AFTERCOMMA: begin
                if (r_phase == shl_pkg::PH_AFTERCOMMA && c == shl_pkg::CH_NUL) begin
                    n_phase = shl_pkg::PH_START;
                    n_acc   = '0;
                end else if (blank) begin
                    n_phase = shl_pkg::PH_START;
                end else if (c == shl_pkg::CH_ZERO) begin
                    n_phase = shl_pkg::PH_GOT0;
                end else begin
                    n_phase = (c == shl_pkg::CH_NUL) ? shl_pkg::PH_START
                                                     : shl_pkg::PH_REJECTED;
                    n_acc   = '0;
                end
            end
            shl_pkg::PH_GOT0: begin
                n_acc = '0;
                if (c == shl_pkg::CH_LOW_X || c == shl_pkg::CH_UP_X) begin
                    n_phase = shl_pkg::PH_FIRSTDIG;
                end else begin
                    n_phase = (c == shl_pkg::CH_NUL) ? shl_pkg::PH_START
                                                     : shl_pkg::PH_REJECTED;
                end
            end
            shl_pkg::PH_FIRSTDIG: begin
                if (hx.ok) begin
                    n_phase = shl_pkg::PH_DIGITS;
                    n_acc   = VALUE_BITS'(hx.d);
                end else begin
                    n_phase = (c == shl_pkg::CH_NUL) ? shl_pkg::PH_START
                                                     : shl_pkg::PH_REJECTED;
                    n_acc   = '0;
                end
            end
            shl_pkg::PH_DIGITS, shl_pkg::PH_TRAIL: begin
                if (hx.ok && r_phase == shl_pkg::PH_DIGITS) begin
                    if (top_busy) begin
                        n_phase = (c == shl_pkg::CH_NUL) ? shl_pkg::PH_START
                                                         : shl_pkg::PH_REJECTED;
                        n_acc   = '0;
                    end else begin
                        n_acc = {r_acc[VALUE_BITS-5:0], hx.d};
                    end
                end else if (blank) begin
                    n_phase = shl_pkg::PH_TRAIL;
                end else begin
                    // token ends: comma, end of list, or junk
                    n_acc = '0;
                    if (r_acc != '0 && c == shl_pkg::CH_COMMA) begin
                        n_phase = shl_pkg::PH_AFTERCOMMA;
                    end else if (c == shl_pkg::CH_NUL) begin
                        n_phase = shl_pkg::PH_START;
                    end else begin
                        n_phase = shl_pkg::PH_REJECTED;
                    end
                end
            end
            default: begin
                // ignore the tail of a rejected list
                if (c == shl_pkg::CH_NUL) begin
                    n_phase = shl_pkg::PH_START;
                    n_acc   = '0;
                end else begin
                    n_phase = shl_pkg::PH_REJECTED;
                end
            end
        endcase
    end

    // result for the current character
    always_comb begin
        n_emit   = 1'b0;
        n_kind   = shl_pkg::KIND_REJECT;
        n_value  = '0;
        n_reason = shl_pkg::RSN_NONE;
        unique case (r_phase) inside
            shl_pkg::PH_START, shl_pkg::PH_AFTERCOMMA: begin
                if (r_phase == shl_pkg::PH_AFTERCOMMA && c == shl_pkg::CH_NUL) begin
                    n_emit   = 1'b1;
                    n_reason = shl_pkg::RSN_COMMA;
                end else if (!blank && c != shl_pkg::CH_ZERO) begin
                    n_emit   = 1'b1;
                    n_reason = shl_pkg::RSN_PREFIX;
                end
            end
            shl_pkg::PH_GOT0: begin
                if (c != shl_pkg::CH_LOW_X && c != shl_pkg::CH_UP_X) begin
                    n_emit   = 1'b1;
                    n_reason = shl_pkg::RSN_PREFIX;
                end
            end
            shl_pkg::PH_FIRSTDIG: begin
                if (!hx.ok) begin
                    n_emit   = 1'b1;
                    n_reason = shl_pkg::RSN_NO_DIGITS;
                end
            end
            shl_pkg::PH_DIGITS, shl_pkg::PH_TRAIL: begin
                if (hx.ok && r_phase == shl_pkg::PH_DIGITS) begin
                    if (top_busy) begin
                        n_emit   = 1'b1;
                        n_reason = shl_pkg::RSN_OVERFLOW;
                    end
                end else if (!blank) begin
                    n_emit = 1'b1;
                    if (r_acc == '0) begin
                        n_reason = shl_pkg::RSN_ZERO;
                    end else if (c == shl_pkg::CH_NUL) begin
                        n_kind  = shl_pkg::KIND_LAST;
                        n_value = shl_pkg::VALUE_W'(r_acc);
                    end else if (c == shl_pkg::CH_COMMA) begin
                        n_kind  = shl_pkg::KIND_MORE;
                        n_value = shl_pkg::VALUE_W'(r_acc);
                    end else begin
                        n_reason = shl_pkg::RSN_JUNK;
                    end
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= shl_pkg::PH_START;
            r_acc   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind   <= n_kind;
            r_value  <= n_value;
            r_reason <= n_reason;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.value         = r_value;
    assign o_out.reject_reason = r_reason;

`ifndef ASSERT_OFF
    // a zero byte always starts a new list
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.ch == shl_pkg::CH_NUL) |=> (r_phase == shl_pkg::PH_START))
        else $error("zero byte did not return parser to token start");

    // rejections carry a reason and no value
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == shl_pkg::KIND_REJECT)
            |-> (r_value == '0 && r_reason != shl_pkg::RSN_NONE))
        else $error("rejection result malformed");

    // emitted values are nonzero and carry no reason
    a_value_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != shl_pkg::KIND_REJECT)
            |-> (r_value != '0 && r_reason == shl_pkg::RSN_NONE))
        else $error("value result malformed");

    // accumulator is clear while waiting for the first digit
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == shl_pkg::PH_FIRSTDIG || r_phase == shl_pkg::PH_AFTERCOMMA)
            |-> (r_acc == '0))
        else $error("accumulator not clear before token digits");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int unsigned VALUE_BITS = 64;
    localparam logic [shl_pkg::VALUE_W-1:0] VALUE_MASK =
        {shl_pkg::VALUE_W{1'b1}} >> (shl_pkg::VALUE_W - VALUE_BITS);
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 275;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    typedef logic [shl_pkg::CH_W-1:0] t_char_q[$];

    typedef struct {
        shl_pkg::t_kind                kind;
        logic [shl_pkg::VALUE_W-1:0]   value;
        shl_pkg::t_reason              reason;
    } t_parse_result;

    logic i_clk;
    logic i_rst_n;

    shl_ch_if  in_if();
    shl_res_if out_if();

    strict_hex_list_parser_core #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // characters waiting to be sent, results still owed by the parser
    logic [shl_pkg::CH_W-1:0]  char_q[$];
    t_parse_result             owed_q[$];
    t_idle                     idle_mode;
    int unsigned               errors;
    int unsigned               cycles;

    // mirror of the parser state
    shl_pkg::t_phase              ph;
    logic [shl_pkg::VALUE_W-1:0]  acc;

    // clock
    always #6 i_clk = ~i_clk;

    // mismatch reporting
    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // predicted results
    function automatic void owe(input shl_pkg::t_kind k,
                                input logic [shl_pkg::VALUE_W-1:0] v,
                                input shl_pkg::t_reason r);
        t_parse_result res;
        res.kind   = k;
        res.value  = v;
        res.reason = r;
        owed_q = {owed_q, res};
    endfunction

    function automatic void reject_list(input logic [shl_pkg::CH_W-1:0] c,
                                        input shl_pkg::t_reason r);
        ph  = (c == shl_pkg::CH_NUL) ? shl_pkg::PH_START : shl_pkg::PH_REJECTED;
        acc = '0;
        owe(shl_pkg::KIND_REJECT, '0, r);
    endfunction

    // terminator or junk after a token's digits
    function automatic void close_token(input logic [shl_pkg::CH_W-1:0] c);
        if (acc == '0) begin
            reject_list(c, shl_pkg::RSN_ZERO);
        end else if (c == shl_pkg::CH_NUL) begin
            owe(shl_pkg::KIND_LAST, acc, shl_pkg::RSN_NONE);
            ph  = shl_pkg::PH_START;
            acc = '0;
        end else if (c == shl_pkg::CH_COMMA) begin
            owe(shl_pkg::KIND_MORE, acc, shl_pkg::RSN_NONE);
            ph  = shl_pkg::PH_AFTERCOMMA;
            acc = '0;
        end else begin
            reject_list(c, shl_pkg::RSN_JUNK);
        end
    endfunction

    // one character through the parser
    function automatic void parse_char(input logic [shl_pkg::CH_W-1:0] c);
        logic       is_dig;
        logic [3:0] dig;
        logic       blank;
        is_dig = 1'b1;
        dig    = 4'd0;
        if (c >= "0" && c <= "9") begin
            dig = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            dig = c[3:0] + 4'd9;
        end else begin
            is_dig = 1'b0;
        end
        blank = (c == shl_pkg::CH_SPACE) || (c == shl_pkg::CH_TAB);
        case (ph)
            shl_pkg::PH_START, shl_pkg::PH_AFTERCOMMA: begin
                if (ph == shl_pkg::PH_AFTERCOMMA && c == shl_pkg::CH_NUL)
                    reject_list(c, shl_pkg::RSN_COMMA);
                else if (blank)
                    ph = shl_pkg::PH_START;
                else if (c == shl_pkg::CH_ZERO)
                    ph = shl_pkg::PH_GOT0;
                else
                    reject_list(c, shl_pkg::RSN_PREFIX);
            end
            shl_pkg::PH_GOT0: begin
                if (c == shl_pkg::CH_LOW_X || c == shl_pkg::CH_UP_X) begin
                    ph  = shl_pkg::PH_FIRSTDIG;
                    acc = '0;
                end else begin
                    reject_list(c, shl_pkg::RSN_PREFIX);
                end
            end
            shl_pkg::PH_FIRSTDIG: begin
                if (!is_dig) begin
                    reject_list(c, shl_pkg::RSN_NO_DIGITS);
                end else begin
                    acc = shl_pkg::VALUE_W'(dig);
                    ph  = shl_pkg::PH_DIGITS;
                end
            end
            shl_pkg::PH_DIGITS: begin
                if (is_dig) begin
                    if (acc > (VALUE_MASK >> 4))
                        reject_list(c, shl_pkg::RSN_OVERFLOW);
                    else
                        acc = (acc << 4) | shl_pkg::VALUE_W'(dig);
                end else if (blank) begin
                    ph = shl_pkg::PH_TRAIL;
                end else begin
                    close_token(c);
                end
            end
            shl_pkg::PH_TRAIL: begin
                if (!blank)
                    close_token(c);
            end
            default: begin
                // ignored tail of a rejected list
                if (c == shl_pkg::CH_NUL) begin
                    ph  = shl_pkg::PH_START;
                    acc = '0;
                end else begin
                    ph = shl_pkg::PH_REJECTED;
                end
            end
        endcase
    endfunction

    // stimulus building
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_q = {char_q, s[i]};
    endtask

    function automatic logic [shl_pkg::CH_W-1:0] hex_char(input int unsigned v);
        if (v < 10)
            return shl_pkg::CH_ZERO + shl_pkg::CH_W'(v);
        return ($urandom_range(1) ? "A" : "a") + shl_pkg::CH_W'(v - 10);
    endfunction

    function automatic logic [shl_pkg::CH_W-1:0] blank_char();
        return $urandom_range(1) ? shl_pkg::CH_SPACE : shl_pkg::CH_TAB;
    endfunction

    task automatic add_token(ref t_char_q s);
        int unsigned r;
        int unsigned n_dig;
        r = $urandom_range(99);
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 2)) s = {s, blank_char()};
        s = {s, shl_pkg::CH_ZERO};
        s = {s, ($urandom_range(1) ? shl_pkg::CH_LOW_X : shl_pkg::CH_UP_X)};
        if (r < 6) begin
            // too long: overflows unless the leading digits beyond sixteen are zero
            n_dig = $urandom_range(17, 18);
            repeat (n_dig) s = {s, hex_char($urandom_range(15))};
        end else if (r < 12) begin
            repeat ($urandom_range(1, 3)) s = {s, shl_pkg::CH_ZERO};
        end else if (r < 16) begin
            repeat (16) s = {s, hex_char(15)};
        end else begin
            n_dig = $urandom_range(1, 16);
            repeat (n_dig) s = {s, hex_char($urandom_range(15))};
        end
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 2)) s = {s, blank_char()};
    endtask

    task automatic add_random_list();
        t_char_q     s;
        int unsigned r;
        int unsigned pos;
        r = $urandom_range(99);
        if (r < 8) begin
            // noise
            repeat ($urandom_range(1, 12))
                s = {s, shl_pkg::CH_W'($urandom_range(1, 255))};
        end else begin
            add_token(s);
            repeat ($urandom_range(0, 3)) begin
                s = {s, shl_pkg::CH_COMMA};
                add_token(s);
            end
            if (r < 30) begin
                // broken list
                pos = $urandom_range(s.size() - 1);
                case ($urandom_range(3))
                    0: s[pos] = shl_pkg::CH_W'($urandom_range(255));
                    1: s = {s, shl_pkg::CH_COMMA};
                    2: begin
                        s = {s, shl_pkg::CH_COMMA};
                        s = {s, blank_char()};
                    end
                    default: s.delete(pos);
                endcase
            end
        end
        s = {s, shl_pkg::CH_NUL};
        foreach (s[i])
            char_q = {char_q, s[i]};
    endtask

    function automatic bit send_hold();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 88;
            IDLE_BOTH: return $urandom_range(99) < 37;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_hold();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 88;
            IDLE_BOTH: return $urandom_range(99) < 37;
            default:   return 1'b0;
        endcase
    endfunction

    // character driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.ch    <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (char_q.size() != 0 && !send_hold()) begin
                in_if.valid <= 1'b1;
                in_if.ch    <= char_q.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= !recv_hold();
    end

    // monitor: check results, then predict from accepted characters
    always @(posedge i_clk) begin : watch
        t_parse_result want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d value %h reason %0d",
                                              out_if.kind, out_if.value, out_if.reject_reason));
                end else begin
                    want = owed_q.pop_front();
                    if (out_if.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  out_if.kind, want.kind));
                    if (out_if.value !== want.value)
                        report_mismatch($sformatf("value %h, want %h",
                                                  out_if.value, want.value));
                    if (out_if.reject_reason !== want.reason)
                        report_mismatch($sformatf("reject_reason %0d, want %0d",
                                                  out_if.reject_reason, want.reason));
                end
            end
            if (in_if.valid && in_if.ready)
                parse_char(in_if.ch);
        end
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    // sequence of the run
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.ch     = '0;
        out_if.ready = 1'b0;
        errors       = 0;
        idle_mode    = IDLE_NONE;
        ph           = shl_pkg::PH_START;
        acc          = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, trailing comma, blanks and both prefixes,
        // zero before junk, no digits, missing prefix with ignored tail
        char_q = {char_q, shl_pkg::CH_NUL};
        push_text("0x1,");
        char_q = {char_q, shl_pkg::CH_NUL};
        push_text("\t0XaF ,0x0 z");
        char_q = {char_q, shl_pkg::CH_NUL};
        push_text("0x");
        char_q = {char_q, shl_pkg::CH_NUL};
        push_text("1");
        char_q = {char_q, 8'hff};
        char_q = {char_q, shl_pkg::CH_NUL};

        // random lists under each idling pattern, draining between them
        for (int m = 0; m < 4; m++) begin
            int unsigned start_n;
            idle_mode = t_idle'(m);
            start_n   = char_q.size();
            while (char_q.size() - start_n < PHASE_ITEMS)
                add_random_list();
            @(posedge i_clk);
            while (char_q.size() != 0 || in_if.valid || owed_q.size() != 0)
                @(posedge i_clk);
            repeat (3) @(posedge i_clk);
        end

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
